@@ rtl/lms_pkg.sv @@
// ---------------------------------------------------------------------------
// LMS system identifier package
// Shared widths, register indexes and the tap cell control bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package lms_pkg;

    // sample, coefficient, weight and error width
    localparam int DataW = 16;

    // configuration register map
    localparam int CfgIdxW  = 3;
    localparam int RegCount = 5;

    localparam logic [CfgIdxW-1:0] RegRefTap0 = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRefTap1 = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRefTap2 = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRefTap3 = 3'd3;
    localparam logic [CfgIdxW-1:0] RegStep    = 3'd4;

    // reset values
    localparam logic [DataW-1:0] RefTapReset = 16'd8192;
    localparam logic [DataW-1:0] StepReset   = 16'd6;

    // number of reference coefficient registers
    localparam int RefRegCount = 4;

    typedef logic [DataW-1:0] t_word;

    // control strobes broadcast to every tap cell
    typedef struct packed {
        logic shift;     // tap line moves one place, new sample enters cell 0
        logic mul;       // form sample*coef and sample*weight
        logic upd_mul;   // form gain*sample
        logic upd_add;   // add the update product to the weight
    } t_cell_ctl;

    // low 16 bits of a product (identical for signed and unsigned operands)
    function automatic t_word mul_lo(input t_word a, input t_word b);
        logic [2*DataW-1:0] p;
        p = a * b;
        return p[DataW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/lms_if.sv @@
// ---------------------------------------------------------------------------
// LMS system identifier channel interfaces
// Sample input stream, error output stream and configuration write channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface lms_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface lms_error_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] error_out;

    modport source (output valid, output error_out, input ready);
    modport sink   (input valid, input error_out, output ready);
endinterface

interface lms_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lms_tap_cell.sv @@
// ---------------------------------------------------------------------------
// LMS tap cell
// Holds one tap sample and its adaptive weight. Forms both filter products,
// adds them to the partial sums passing along the chain, and updates its
// weight from the broadcast gain.
// ---------------------------------------------------------------------------
`default_nettype none

module lms_tap_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  lms_pkg::t_cell_ctl  i_ctl,
    input  lms_pkg::t_word      i_sample,   // from previous cell (or new sample)
    input  lms_pkg::t_word      i_coef,     // reference coefficient
    input  lms_pkg::t_word      i_gain,     // step * error
    input  wire                 i_tok,      // partial sums valid on input
    input  lms_pkg::t_word      i_ref_sum,
    input  lms_pkg::t_word      i_ada_sum,
    output lms_pkg::t_word      o_sample,
    output logic                o_tok,
    output lms_pkg::t_word      o_ref_sum,
    output lms_pkg::t_word      o_ada_sum
);

    lms_pkg::t_word r_sample;
    lms_pkg::t_word r_weight;
    lms_pkg::t_word r_prod_a;   // ref product, later update product
    lms_pkg::t_word r_prod_b;   // adaptive product
    lms_pkg::t_word r_ref_sum;
    lms_pkg::t_word r_ada_sum;
    logic           r_tok;

    // tap state: sample and weight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_weight <= '0;
        end else begin
            if (i_ctl.shift) begin
                r_sample <= i_sample;
            end
            if (i_ctl.upd_add) begin
                r_weight <= r_weight + r_prod_a;
            end
        end
    end

    // products, registered before any add
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod_a <= lms_pkg::mul_lo(r_sample, i_coef);
            r_prod_b <= lms_pkg::mul_lo(r_sample, r_weight);
        end else if (i_ctl.upd_mul) begin
            r_prod_a <= lms_pkg::mul_lo(i_gain, r_sample);
        end
    end

    // partial sum wavefront
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_ref_sum <= i_ref_sum + r_prod_a;
            r_ada_sum <= i_ada_sum + r_prod_b;
        end
    end

    assign o_sample  = r_sample;
    assign o_tok     = r_tok;
    assign o_ref_sum = r_ref_sum;
    assign o_ada_sum = r_ada_sum;

endmodule

`default_nettype wire

@@ rtl/lms_system_identifier.sv @@
// ---------------------------------------------------------------------------
// LMS system identifier
// Fixed reference FIR and adaptive FIR over a shared tap line; emits the
// error (reference minus adaptive) and adapts the weights by step*err*tap.
// All arithmetic wraps at 16 bits.
// ---------------------------------------------------------------------------
//
//  Channel    Dir  Fields             Transfer when
//  i_sample   in   sample_in[15:0]    valid && ready
//  o_error    out  error_out[15:0]    valid && ready
//  i_cfg      in   index[2:0], data   valid && ready (ready always high)
//
//  One sample is in flight at a time. The sequencer takes the sample, forms
//  the products and launches the partial sums, which then walk the cell chain
//  one cell per cycle; then come the gain, the update product, the weight add
//  and the output load, each a state of its own.
//  Reset loads the reference taps with 8192, step with 6, clears taps and
//  weights. A stalled output holds the sequencer in its output state until
//  the previous error has left the output register; the next sample is taken
//  on the cycle after the new error is loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module lms_system_identifier #(
    parameter int TAP_COUNT = 4
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    lms_sample_if.sink  i_sample,
    lms_error_if.source o_error,
    lms_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LAUNCH,
        S_SUM,
        S_GAIN,
        S_UPD_MUL,
        S_UPD_ADD,
        S_OUT
    } t_state;

    t_state         r_state;
    lms_pkg::t_word r_ref_tap [lms_pkg::RefRegCount];
    lms_pkg::t_word r_step;
    lms_pkg::t_word r_err;
    lms_pkg::t_word r_gain;
    logic           r_out_valid;
    lms_pkg::t_word r_out_data;

    lms_pkg::t_cell_ctl cell_ctl;
    logic               accept;
    logic               load_out;

    lms_pkg::t_word sample_chain [TAP_COUNT+1];
    lms_pkg::t_word ref_chain    [TAP_COUNT+1];
    lms_pkg::t_word ada_chain    [TAP_COUNT+1];
    logic           tok_chain    [TAP_COUNT+1];

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lms_pkg::RefRegCount; k++) begin
                r_ref_tap[k] <= lms_pkg::RefTapReset;
            end
            r_step <= lms_pkg::StepReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lms_pkg::RegRefTap0: r_ref_tap[0] <= i_cfg.data;
                lms_pkg::RegRefTap1: r_ref_tap[1] <= i_cfg.data;
                lms_pkg::RegRefTap2: r_ref_tap[2] <= i_cfg.data;
                lms_pkg::RegRefTap3: r_ref_tap[3] <= i_cfg.data;
                lms_pkg::RegStep:    r_step       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input handshake and cell strobes
    assign i_sample.ready = (r_state == S_IDLE);
    assign accept         = i_sample.valid && (r_state == S_IDLE);

    // output register can take a new error
    assign load_out = (r_state == S_OUT) && (!r_out_valid || o_error.ready);

    always_comb begin
        cell_ctl.shift   = accept;
        cell_ctl.mul     = (r_state == S_MUL);
        cell_ctl.upd_mul = (r_state == S_UPD_MUL);
        cell_ctl.upd_add = (r_state == S_UPD_ADD);
    end

    // cell chain
    assign sample_chain[0] = i_sample.sample_in;
    assign tok_chain[0]    = (r_state == S_LAUNCH);
    assign ref_chain[0]    = '0;
    assign ada_chain[0]    = '0;

    for (genvar j = 0; j < TAP_COUNT; j++) begin : g_cell
        lms_tap_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_sample  (sample_chain[j]),
            .i_coef    (r_ref_tap[j]),
            .i_gain    (r_gain),
            .i_tok     (tok_chain[j]),
            .i_ref_sum (ref_chain[j]),
            .i_ada_sum (ada_chain[j]),
            .o_sample  (sample_chain[j+1]),
            .o_tok     (tok_chain[j+1]),
            .o_ref_sum (ref_chain[j+1]),
            .o_ada_sum (ada_chain[j+1])
        );
    end

    // sequencer with error, gain and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= load_out || (r_out_valid && !o_error.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:    r_state <= S_LAUNCH;
                S_LAUNCH: r_state <= S_SUM;
                S_SUM: begin
                    if (tok_chain[TAP_COUNT]) begin
                        r_err   <= ref_chain[TAP_COUNT] - ada_chain[TAP_COUNT];
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_gain  <= lms_pkg::mul_lo(r_step, r_err);
                    r_state <= S_UPD_MUL;
                end
                S_UPD_MUL: r_state <= S_UPD_ADD;
                S_UPD_ADD: r_state <= S_OUT;
                S_OUT: begin
                    if (load_out) begin
                        r_out_data <= r_err;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_error.valid     = r_out_valid;
    assign o_error.error_out = r_out_data;

endmodule

`default_nettype wire

@@ test/lms_error_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LMS system identifier error checker
// Watches the sample, error and configuration channels, runs its own copy of
// the filter pair and the weight adaptation on every sample transfer, and
// compares each error transfer with the oldest predicted error.
// ---------------------------------------------------------------------------

module lms_error_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    lms_sample_if sample_ch,
    lms_error_if  error_ch,
    lms_cfg_if    cfg_ch,
    output int    o_mismatch_count,
    output int    o_errors_due
);

    localparam int Taps = 4;

    // predictor state: register copies, tap line (entry 0 = newest), weights
    lms_pkg::t_word ref_taps [Taps];
    lms_pkg::t_word step_gain;
    lms_pkg::t_word tap_line [Taps];
    lms_pkg::t_word weights  [Taps];
    lms_pkg::t_word predicted_errors [$];
    lms_pkg::t_word want;

    // one LMS iteration, all arithmetic wrapping at 16 bits
    function automatic lms_pkg::t_word lms_next_error(input lms_pkg::t_word sample);
        lms_pkg::t_word ref_sum;
        lms_pkg::t_word ada_sum;
        lms_pkg::t_word err;
        lms_pkg::t_word gain;
        ref_sum     = '0;
        ada_sum     = '0;
        tap_line[0] = sample;
        for (int j = 0; j < Taps; j++) begin
            ref_sum = ref_sum + tap_line[j] * ref_taps[j];
            ada_sum = ada_sum + tap_line[j] * weights[j];
        end
        err  = ref_sum - ada_sum;
        gain = step_gain * err;
        for (int j = 0; j < Taps; j++) begin
            weights[j] = weights[j] + gain * tap_line[j];
        end
        for (int j = Taps - 1; j > 0; j--) begin
            tap_line[j] = tap_line[j-1];
        end
        return err;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < Taps; j++) begin
                ref_taps[j] = lms_pkg::RefTapReset;
                tap_line[j] = '0;
                weights[j]  = '0;
            end
            step_gain = lms_pkg::StepReset;
            predicted_errors.delete();
            o_mismatch_count <= 0;
            o_errors_due     <= 0;
        end else begin
            // register writes; indexes past the step register are dropped
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    lms_pkg::RegRefTap0: ref_taps[0] = cfg_ch.data;
                    lms_pkg::RegRefTap1: ref_taps[1] = cfg_ch.data;
                    lms_pkg::RegRefTap2: ref_taps[2] = cfg_ch.data;
                    lms_pkg::RegRefTap3: ref_taps[3] = cfg_ch.data;
                    lms_pkg::RegStep:    step_gain   = cfg_ch.data;
                    default: ;
                endcase
            end

            // predict on every accepted sample
            if (sample_ch.valid && sample_ch.ready) begin
                predicted_errors.push_back(lms_next_error(sample_ch.sample_in));
            end

            // compare each error transfer against the oldest prediction
            if (error_ch.valid && error_ch.ready) begin
                if (predicted_errors.size() == 0) begin
                    $display("%0d ns: unexpected error_out transfer, expected none, actual %0d",
                             $time, error_ch.error_out);
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = predicted_errors.pop_front();
                    if (want !== error_ch.error_out) begin
                        $display("%0d ns: error_out mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), error_ch.error_out);
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                end
            end

            o_errors_due <= predicted_errors.size();
        end
    end

endmodule

@@ test/lms_system_identifier_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LMS system identifier testbench
// Drives samples and register writes into the block under random back
// pressure; the error checker beside it predicts and compares every error.
// Directed corner samples first, then random samples over several settings.
// ---------------------------------------------------------------------------

module lms_system_identifier_test;

    localparam int SegmentItems  = 108;
    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int src_idle_pct;
    int sink_idle_pct;
    int mismatch_count;
    int errors_due;
    int quiet_cycles;

    lms_sample_if sample_ch ();
    lms_error_if  error_ch ();
    lms_cfg_if    cfg_ch ();

    lms_system_identifier u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_error  (error_ch),
        .i_cfg    (cfg_ch)
    );

    lms_error_checker u_error_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .sample_ch        (sample_ch),
        .error_ch         (error_ch),
        .cfg_ch           (cfg_ch),
        .o_mismatch_count (mismatch_count),
        .o_errors_due     (errors_due)
    );

    always #2 i_clk = ~i_clk;

    // random back pressure on the error output
    always @(negedge i_clk) begin
        error_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready) ||
            (error_ch.valid && error_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // all tasks are entered and left at a falling edge

    // one sample transfer, with random idle cycles ahead of it
    task automatic send_sample(input lms_pkg::t_word value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            sample_ch.valid     <= 1'b0;
            sample_ch.sample_in <= lms_pkg::t_word'($urandom);
            @(negedge i_clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_in <= value;
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
    endtask

    // hold samples back until every predicted error has left the block
    task automatic wait_for_errors();
        sample_ch.valid <= 1'b0;
        while (errors_due != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [lms_pkg::CfgIdxW-1:0] idx,
                             input lms_pkg::t_word value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // new filter setting, only once the block has gone idle
    task automatic load_setting(input lms_pkg::t_word tap0, input lms_pkg::t_word tap1,
                                input lms_pkg::t_word tap2, input lms_pkg::t_word tap3,
                                input lms_pkg::t_word step);
        wait_for_errors();
        cfg_write(lms_pkg::RegRefTap0, tap0);
        cfg_write(lms_pkg::RegRefTap1, tap1);
        cfg_write(lms_pkg::RegRefTap2, tap2);
        cfg_write(lms_pkg::RegRefTap3, tap3);
        cfg_write(lms_pkg::RegStep, step);
    endtask

    // random word for setting and sample fields
    function automatic lms_pkg::t_word rand_word();
        return lms_pkg::t_word'($urandom);
    endfunction

    // mostly full-range samples, with some extremes and some small values
    function automatic lms_pkg::t_word pick_sample();
        lms_pkg::t_word s;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: s = 16'h7FFF;
                    1: s = 16'h8000;
                    2: s = 16'hFFFF;
                    3: s = 16'h0001;
                    default: s = 16'h0000;
                endcase
            end
            1, 2: s = lms_pkg::t_word'($urandom_range(0, 31)) - 16'd16;
            default: s = rand_word();
        endcase
        return s;
    endfunction

    task automatic random_samples(input int count);
        for (int n = 0; n < count; n++) begin
            send_sample(pick_sample());
            if ($urandom_range(0, 49) == 0) wait_for_errors();
        end
    endtask

    initial begin
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = lms_pkg::RegRefTap0;
        cfg_ch.data         = '0;
        error_ch.ready      = 1'b0;
        src_idle_pct        = 16;
        sink_idle_pct       = 47;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: corner samples
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'hAAAA);

        // writes past the step register must leave the setting untouched
        wait_for_errors();
        for (int k = lms_pkg::RegCount; k < 2**lms_pkg::CfgIdxW; k++) begin
            cfg_write(k[lms_pkg::CfgIdxW-1:0], rand_word());
        end
        send_sample(16'h04D2);
        send_sample(16'hFB2E);

        // extreme coefficients and gain: wrap everywhere
        load_setting(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);

        // zero reference and zero gain: error is minus the frozen adaptive sum
        load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0064);
        send_sample(16'hFF9C);
        send_sample(16'h7FFF);

        // random part, sender idling less than the receiver
        load_setting(rand_word(), rand_word(), rand_word(), rand_word(), 16'h0001);
        random_samples(SegmentItems);
        load_setting(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h7FFF);
        random_samples(SegmentItems);

        // receiver idling less than the sender
        src_idle_pct  = 47;
        sink_idle_pct = 16;
        load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        random_samples(SegmentItems);
        load_setting(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        random_samples(SegmentItems);

        // no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        random_samples(SegmentItems);
        load_setting(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        random_samples(SegmentItems);

        wait_for_errors();
        if (mismatch_count == 0 && errors_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
